### src/vls_pkg.sv
// Shared types and constants of the van Leer slope limiter.
`default_nettype none
package vls_pkg;

    // Fraction bits of the ratio and gradient inputs (8 to 30).
    localparam int FRACTION_BITS = 16;
    // Fraction bits of the limiter value (fixed Q2.16).
    localparam int LIM_FRAC = 16;
    // Limiter width; also the number of divider cells, one quotient bit each.
    localparam int LIM_W = 18;
    // Data width of ratio, gradient and limited slope.
    localparam int DATA_W = 32;
    // Divisor and partial remainder width.
    localparam int DEN_W = 32;
    // Full dividend width.
    localparam int NUM_W = DEN_W + LIM_W;
    // Product width: unsigned limiter made signed, times the gradient.
    localparam int PROD_W = LIM_W + 1 + DATA_W;

    localparam logic [DEN_W-1:0] ONE = DEN_W'(1) << FRACTION_BITS;
    // Right-limit dividend 2^(FRACTION_BITS+LIM_FRAC+1); its low LIM_W bits are zero.
    localparam logic [NUM_W-1:0] NUM_RIGHT = NUM_W'(1) << (FRACTION_BITS + LIM_FRAC + 1);
    localparam logic [DEN_W-1:0] REM_RIGHT_INIT = NUM_RIGHT[NUM_W-1:LIM_W];

    localparam logic OP_PLAIN = 1'b0;
    localparam logic OP_RIGHT = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic signed [DATA_W-1:0] ratio_value;
        logic signed [DATA_W-1:0] slope_value;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] limited_slope;
        logic [LIM_W-1:0]         limiter_value;
        logic                     saturated;
    } result_t;

    // Beat handed from one divider cell to the next.
    typedef struct packed {
        logic                     operation;
        logic                     negative;
        logic [DEN_W-1:0]         den;
        logic [DEN_W-1:0]         rem_l;
        logic [DEN_W-1:0]         rem_m;
        logic [LIM_W-1:0]         num_bits;
        logic [LIM_W-1:0]         quo_l;
        logic [LIM_W-1:0]         quo_m;
        logic signed [DATA_W-1:0] slope;
    } div_beat_t;

endpackage
`default_nettype wire

### src/vls_div_cell.sv
// One restoring-division cell: resolves one quotient bit of both quotients.
`default_nettype none
module vls_div_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire vls_pkg::div_beat_t in_beat,
    output logic                    out_valid,
    output vls_pkg::div_beat_t      out_beat
);

    logic                     valid_reg;
    vls_pkg::div_beat_t       beat_reg;
    vls_pkg::div_beat_t       beat_next;
    logic [vls_pkg::DEN_W:0]   ext_l;
    logic [vls_pkg::DEN_W:0]   ext_m;
    logic [vls_pkg::DEN_W+1:0] diff_l;
    logic [vls_pkg::DEN_W+1:0] diff_m;
    logic                     take_l;
    logic                     take_m;

    // Shift in the next dividend bit and trial-subtract the divisor
    always_comb
    begin
        ext_l  = {in_beat.rem_l, in_beat.num_bits[vls_pkg::LIM_W-1]};
        ext_m  = {in_beat.rem_m, 1'b0};
        diff_l = {1'b0, ext_l} - {2'b00, in_beat.den};
        diff_m = {1'b0, ext_m} - {2'b00, in_beat.den};
        take_l = ~diff_l[vls_pkg::DEN_W+1];
        take_m = ~diff_m[vls_pkg::DEN_W+1];

        beat_next          = in_beat;
        beat_next.rem_l    = take_l ? diff_l[vls_pkg::DEN_W-1:0] : ext_l[vls_pkg::DEN_W-1:0];
        beat_next.rem_m    = take_m ? diff_m[vls_pkg::DEN_W-1:0] : ext_m[vls_pkg::DEN_W-1:0];
        beat_next.num_bits = {in_beat.num_bits[vls_pkg::LIM_W-2:0], 1'b0};
        beat_next.quo_l    = {in_beat.quo_l[vls_pkg::LIM_W-2:0], take_l};
        beat_next.quo_m    = {in_beat.quo_m[vls_pkg::LIM_W-2:0], take_m};
    end

    // Advance the valid mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule
`default_nettype wire

### src/vls_post.sv
// Limiter selection, gradient multiply, floor shift and saturation stages.
`default_nettype none
module vls_post (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire vls_pkg::div_beat_t in_beat,
    output logic                    done,
    output vls_pkg::result_t        result
);

    logic                              mul_valid_reg;
    logic [vls_pkg::LIM_W-1:0]         lim_next;
    logic [vls_pkg::LIM_W-1:0]         lim_reg;
    logic signed [vls_pkg::PROD_W-1:0] prod_next;
    logic signed [vls_pkg::PROD_W-1:0] prod_reg;

    logic signed [vls_pkg::PROD_W-1:0] shifted;
    logic                              over_pos;
    logic                              over_neg;
    logic                              done_reg;
    vls_pkg::result_t                  result_next;
    vls_pkg::result_t                  result_reg;

    // Pick the limiter and form the exact product
    always_comb
    begin
        if (in_beat.negative)
        begin
            lim_next = '0;
        end
        else if (in_beat.operation == vls_pkg::OP_RIGHT && in_beat.quo_m < in_beat.quo_l)
        begin
            lim_next = in_beat.quo_m;
        end
        else
        begin
            lim_next = in_beat.quo_l;
        end
        prod_next = $signed({1'b0, lim_next}) * in_beat.slope;
    end

    // Drop the limiter fraction toward minus infinity and clip to 32 bits
    always_comb
    begin
        shifted  = prod_reg >>> vls_pkg::LIM_FRAC;
        over_pos = ~shifted[vls_pkg::PROD_W-1]
                   & (|shifted[vls_pkg::PROD_W-2:vls_pkg::DATA_W-1]);
        over_neg = shifted[vls_pkg::PROD_W-1]
                   & ~(&shifted[vls_pkg::PROD_W-2:vls_pkg::DATA_W-1]);
        result_next.limiter_value = lim_reg;
        result_next.saturated     = over_pos | over_neg;
        if (over_pos)
        begin
            result_next.limited_slope = {1'b0, {(vls_pkg::DATA_W-1){1'b1}}};
        end
        else if (over_neg)
        begin
            result_next.limited_slope = {1'b1, {(vls_pkg::DATA_W-1){1'b0}}};
        end
        else
        begin
            result_next.limited_slope = shifted[vls_pkg::DATA_W-1:0];
        end
    end

    // Advance the valid marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= in_valid;
            done_reg      <= mul_valid_reg;
        end
    end

    // Hold payload of both stages
    always_ff @(posedge clk)
    begin
        lim_reg    <= lim_next;
        prod_reg   <= prod_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

### src/van_leer_slope_limiter.sv
// Top level of the van Leer slope limiter: divider cell chain and output stages.
//
// Usage: drive item (operation, ratio_value, slope_value) and raise start for
// one cycle per beat. A beat is taken at every rising edge with start high and
// busy low; busy is always low, so a new beat may enter every cycle.
// Each beat yields exactly one result beat on result, marked by done for one
// cycle, in input order.
// Stages: 18 division cells (one quotient bit of 2r/(1+r) and of 2/(1+r)
// per cell, both computed side by side), a stage for limiter selection and
// the 19x32 multiply, and a stage for floor shift and saturation.
// Throughput: one beat per cycle, set by the fully pipelined cell chain.
// Reset clears all valid marks; no result appears until beats are fed.
// The receiver cannot stall: each result must be taken in its done cycle.
`default_nettype none
module van_leer_slope_limiter (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire vls_pkg::item_t item,
    output logic                done,
    output vls_pkg::result_t    result
);

    logic [vls_pkg::NUM_W-1:0] num_l;
    vls_pkg::div_beat_t        entry_beat;
    logic                      entry_valid;
    logic                      chain_valid [vls_pkg::LIM_W+1];
    vls_pkg::div_beat_t        chain_beat  [vls_pkg::LIM_W+1];

    assign busy        = 1'b0;
    assign entry_valid = start & ~busy;

    // Form dividend heads and the divisor 1 + r
    always_comb
    begin
        num_l = vls_pkg::NUM_W'(item.ratio_value[vls_pkg::DATA_W-2:0])
                << (vls_pkg::LIM_FRAC + 1);
        entry_beat.operation = item.operation;
        entry_beat.negative  = item.ratio_value[vls_pkg::DATA_W-1];
        entry_beat.den       = vls_pkg::DEN_W'(item.ratio_value[vls_pkg::DATA_W-2:0])
                               + vls_pkg::ONE;
        entry_beat.rem_l     = num_l[vls_pkg::NUM_W-1:vls_pkg::LIM_W];
        entry_beat.rem_m     = vls_pkg::REM_RIGHT_INIT;
        entry_beat.num_bits  = num_l[vls_pkg::LIM_W-1:0];
        entry_beat.quo_l     = '0;
        entry_beat.quo_m     = '0;
        entry_beat.slope     = item.slope_value;
    end

    assign chain_valid[0] = entry_valid;
    assign chain_beat[0]  = entry_beat;

    // Chain of division cells, most significant quotient bit first
    for (genvar k = 0; k < vls_pkg::LIM_W; k++)
    begin : g_cell
        vls_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .in_beat   (chain_beat[k]),
            .out_valid (chain_valid[k+1]),
            .out_beat  (chain_beat[k+1])
        );
    end

    vls_post u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chain_valid[vls_pkg::LIM_W]),
        .in_beat  (chain_beat[vls_pkg::LIM_W]),
        .done     (done),
        .result   (result)
    );

endmodule
`default_nettype wire

### bench/tb_van_leer_slope_limiter.sv
// Self-checking testbench for the van Leer slope limiter: directed and random beats.
`timescale 1ns / 1ps

module tb_van_leer_slope_limiter;

    // Pipeline depth from input beat to result beat
    localparam int LATENCY      = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 50;

    localparam logic signed [vls_pkg::DATA_W-1:0] D_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [vls_pkg::DATA_W-1:0] D_MIN = 32'sh8000_0000;
    localparam logic signed [vls_pkg::DATA_W-1:0] R_ONE = vls_pkg::ONE;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             done;
    vls_pkg::item_t   item;
    vls_pkg::result_t result;

    // Expected result beats, oldest first
    vls_pkg::result_t pending_results[$];

    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned beats_sent;
    int unsigned results_seen;
    int unsigned negative_ratios;
    int unsigned saturated_products;
    int unsigned right_limit_wins;
    int unsigned right_mode_beats;

    van_leer_slope_limiter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    // Clock: 10 ns period
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Compute the limiter and the limited, saturated slope for one beat
    function automatic vls_pkg::result_t limit_slope(input vls_pkg::item_t b);
        vls_pkg::result_t res;
        longint  r;
        longint  g;
        longint  den;
        longint  lim;
        longint  right;
        longint  q;
        res = '0;
        r = longint'(b.ratio_value);
        g = longint'(b.slope_value);
        if (r >= 0)
        begin
            den = r + (longint'(1) <<< vls_pkg::FRACTION_BITS);
            lim = (r <<< (vls_pkg::LIM_FRAC + 1)) / den;
            if (b.operation == vls_pkg::OP_RIGHT)
            begin
                right = (longint'(1) <<< (vls_pkg::FRACTION_BITS + vls_pkg::LIM_FRAC + 1))
                        / den;
                if (right < lim)
                    lim = right;
            end
            // Arithmetic shift of the signed product rounds toward minus infinity
            q = (lim * g) >>> vls_pkg::LIM_FRAC;
            if (q > longint'(D_MAX))
            begin
                q = longint'(D_MAX);
                res.saturated = 1'b1;
            end
            else if (q < longint'(D_MIN))
            begin
                q = longint'(D_MIN);
                res.saturated = 1'b1;
            end
            res.limited_slope = q[vls_pkg::DATA_W-1:0];
            res.limiter_value = lim[vls_pkg::LIM_W-1:0];
        end
        return res;
    endfunction

    // Print one mismatch line (up to a cap) and count it
    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Record accepted beats and check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        vls_pkg::result_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                want = limit_slope(item);
                pending_results.push_back(want);
                beats_sent++;
                if (item.ratio_value < 0)
                    negative_ratios++;
                if (item.operation == vls_pkg::OP_RIGHT)
                    right_mode_beats++;
                if (want.saturated)
                    saturated_products++;
                if (item.operation == vls_pkg::OP_RIGHT && item.ratio_value > R_ONE)
                    right_limit_wins++;
            end
            if (done)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result beat", 1, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (result.limited_slope !== want.limited_slope)
                        report_mismatch("limited_slope", longint'(result.limited_slope),
                                        longint'(want.limited_slope));
                    if (result.limiter_value !== want.limiter_value)
                        report_mismatch("limiter_value", longint'(result.limiter_value),
                                        longint'(want.limiter_value));
                    if (result.saturated !== want.saturated)
                        report_mismatch("saturated", longint'(result.saturated),
                                        longint'(want.saturated));
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Drive one beat and hold it until the block takes it
    task automatic send_beat(input logic op, input logic signed [vls_pkg::DATA_W-1:0] ratio,
                             input logic signed [vls_pkg::DATA_W-1:0] slope);
        @(negedge clk);
        start <= 1'b1;
        item  <= '{operation: op, ratio_value: ratio, slope_value: slope};
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // Hold start low for a number of cycles
    task automatic hold_off(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Hold start low until every expected result beat has arrived
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        while (pending_results.size() != 0);
    endtask

    // Draw a ratio biased toward the interesting regions of the limiter
    function automatic logic signed [vls_pkg::DATA_W-1:0] random_ratio();
        int unsigned pick;
        pick = $urandom_range(7);
        case (pick)
            0, 1:    return $urandom;
            2:       return -$signed({1'b0,
                                      31'($urandom_range(4 * (1 << vls_pkg::FRACTION_BITS)))});
            3, 4:    return $urandom_range(4 * (1 << vls_pkg::FRACTION_BITS));
            5:       return R_ONE + $signed(32'($urandom_range(64))) - 32;
            6:       return {1'b0, 31'($urandom)};
            default: return $urandom_range(7) == 0 ? D_MAX : $urandom_range(16);
        endcase
    endfunction

    // Draw a gradient: mostly full range, sometimes small or extreme
    function automatic logic signed [vls_pkg::DATA_W-1:0] random_slope();
        int unsigned pick;
        pick = $urandom_range(7);
        case (pick)
            0:       return $signed(32'($urandom_range(1 << 20))) - (1 << 19);
            1:       return $urandom_range(1) ? D_MAX : D_MIN;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_negative_ratio();
        send_beat(vls_pkg::OP_PLAIN, -1, D_MAX);
        send_beat(vls_pkg::OP_RIGHT, D_MIN, D_MIN);
        send_beat(vls_pkg::OP_PLAIN, -R_ONE, 32'sd12345);
        send_beat(vls_pkg::OP_RIGHT, -R_ONE, -32'sd1);
    endtask

    task automatic test_zero_ratio();
        send_beat(vls_pkg::OP_PLAIN, 0, D_MAX);
        send_beat(vls_pkg::OP_RIGHT, 0, D_MIN);
    endtask

    // Cross the point r = 1 where the right-side bound takes over
    task automatic test_right_limit();
        send_beat(vls_pkg::OP_PLAIN, R_ONE, R_ONE);
        send_beat(vls_pkg::OP_RIGHT, R_ONE, -R_ONE);
        send_beat(vls_pkg::OP_RIGHT, R_ONE - 1, D_MAX);
        send_beat(vls_pkg::OP_RIGHT, R_ONE + 1, D_MAX);
        send_beat(vls_pkg::OP_PLAIN, R_ONE + 1, D_MAX);
        send_beat(vls_pkg::OP_RIGHT, D_MAX, D_MAX);
        send_beat(vls_pkg::OP_RIGHT, R_ONE >>> 2, 32'sd1);
    endtask

    task automatic test_saturation();
        send_beat(vls_pkg::OP_PLAIN, D_MAX, D_MAX);
        send_beat(vls_pkg::OP_PLAIN, D_MAX, D_MIN);
        send_beat(vls_pkg::OP_PLAIN, 7 * R_ONE, 32'sh5000_0000);
        send_beat(vls_pkg::OP_PLAIN, 7 * R_ONE, -32'sh5000_0000);
    endtask

    task automatic test_field_extremes();
        send_beat(vls_pkg::OP_PLAIN, 1, D_MAX);
        send_beat(vls_pkg::OP_PLAIN, 4 * R_ONE, -32'sd1);
        send_beat(vls_pkg::OP_PLAIN, 3 * R_ONE, 32'sh4000_0000);
        send_beat(vls_pkg::OP_RIGHT, 3 * R_ONE, 0);
    endtask

    // Random beats; idle_pct is the share of cycles in percent with start held low
    task automatic test_random_stream(input int count, input int idle_pct);
        for (int i = 0; i < count; i++)
        begin
            send_beat(logic'($urandom_range(1)), random_ratio(), random_slope());
            // Insert idle cycles singly, each with the given chance
            while ($urandom_range(99) < idle_pct)
                hold_off(1);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        cycle_count        = 0;
        mismatch_count     = 0;
        beats_sent         = 0;
        results_seen       = 0;
        negative_ratios    = 0;
        saturated_products = 0;
        right_limit_wins   = 0;
        right_mode_beats   = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_negative_ratio();
        test_zero_ratio();
        test_right_limit();
        test_saturation();
        test_field_extremes();
        wait_drained();

        test_random_stream(500, 0);
        wait_drained();
        test_random_stream(500, 88);
        wait_drained();
        test_random_stream(500, 12);

        // Let the pipeline empty, then allow stray beats to show up
        wait_drained();
        repeat (LATENCY + 5) @(posedge clk);

        $display("covered %0d beats (%0d right-limited, %0d above r = 1 there), %0d results",
                 beats_sent, right_mode_beats, right_limit_wins, results_seen);
        $display("negative ratios %0d, saturated products %0d, mismatches %0d",
                 negative_ratios, saturated_products, mismatch_count);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
